>>> src/xml_token_scanner_macros.svh
// assertion helpers shared by the scanner rtl
`ifndef XML_TOKEN_SCANNER_MACROS_SVH
`define XML_TOKEN_SCANNER_MACROS_SVH

// same-cycle implication, sampled on aclk, off while in reset
`define XTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while in reset
`define XTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/xts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xts_pkg
// types, codes and byte constants of the xml token scanner
// ----------------------------------------------------------------------------
package xts_pkg;

    typedef enum logic [3:0] {
        S_TEXT       = 4'd0,
        S_NAME_BEGIN = 4'd1,
        S_NAME       = 4'd2,
        S_ATTR_BEGIN = 4'd3,
        S_ATTR       = 4'd4,
        S_VAL_QUOTE  = 4'd5,
        S_VAL_DQ     = 4'd6,
        S_VAL_SQ     = 4'd7,
        S_VAL_NOQ    = 4'd8,
        S_CLOSE      = 4'd9,
        S_CLOSE_NAME = 4'd10
    } scan_state_t;

    localparam logic [1:0] KIND_VALUE = 2'd0;
    localparam logic [1:0] KIND_EVENT = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] TOK_TEXT       = 3'd0;
    localparam logic [2:0] TOK_TAG_OPEN   = 3'd1;
    localparam logic [2:0] TOK_ATTRS_END  = 3'd2;
    localparam logic [2:0] TOK_ATTR_NAME  = 3'd3;
    localparam logic [2:0] TOK_ATTR_VALUE = 3'd4;
    localparam logic [2:0] TOK_CLOSE_NAME = 3'd5;
    localparam logic [2:0] TOK_SELF_CLOSE = 3'd6;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SP    = 8'h20;

    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  vbyte;
        logic [2:0]  code;
        logic [31:0] line;
        logic [31:0] col;
        logic        last;
    } res_t;

    typedef struct packed {
        res_t        res0;
        res_t        res1;
        logic [1:0]  n;
        logic        err;
        scan_state_t state_next;
        logic        nonempty_next;
        logic [31:0] line_next;
        logic [31:0] col_next;
    } step_t;

    function automatic res_t mk_value(input logic [7:0] b, input logic [2:0] code);
        res_t r;
        r       = '0;
        r.kind  = KIND_VALUE;
        r.vbyte = b;
        r.code  = code;
        return r;
    endfunction

    function automatic res_t mk_event(input logic [2:0] code);
        res_t r;
        r      = '0;
        r.kind = KIND_EVENT;
        r.code = code;
        return r;
    endfunction

endpackage

>>> src/xml_token_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_token_scanner
// streaming xml tokenizer: one document byte per request, value bytes,
// token events and quote errors out, with line and column
// ----------------------------------------------------------------------------
// channel  | dir | handshake                 | payload
// s_       | in  | s_tvalid / s_tready       | tdata: in_byte
// m_       | out | m_tvalid / m_tready       | tdata/tuser/tlast: one result
// cfg_wr_  | in  | cfg_wr_en (no wait)       | cfg_wr_data: strict_quotes
//
// a byte is taken into the input register, scanned there once the result register
// can take its results, which land in the two-entry result register; one byte per
// cycle goes through while m_tready is high and each byte gives at most one result,
// a byte with two results holds the input register while the result register drains.
// aresetn (synchronous) clears the scanner state, counters and strict flag.
// m_tready low stalls the result register and then s_tready.
// ----------------------------------------------------------------------------
`include "xml_token_scanner_macros.svh"

module xml_token_scanner (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,   // strict_quotes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] value_byte, [10:8] token_code, [42:11] line_number,
    // [74:43] column_number, [79:75] zero
    output logic [79:0] m_tdata,
    output logic [1:0]  m_tuser,       // [1:0] result_kind
    output logic        m_tlast        // last_of_run
);
    import xts_pkg::*;

    logic        strict_reg;
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  in_byte_reg;
    scan_state_t state_reg;
    logic        nonempty_reg;
    logic [31:0] line_reg;
    logic [31:0] col_reg;
    step_t       step;
    logic        can_load;
    logic        consume;
    res_t        head;

    assign consume       = in_valid_reg && can_load;
    assign s_tready      = !in_valid_reg || consume;
    assign in_valid_next = (s_tvalid && s_tready) || (in_valid_reg && !consume);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strict_reg   <= 1'b0;
            in_valid_reg <= 1'b0;
            state_reg    <= S_TEXT;
            nonempty_reg <= 1'b0;
            line_reg     <= '0;
            col_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                strict_reg <= cfg_wr_data;
            end
            in_valid_reg <= in_valid_next;
            if (consume) begin
                state_reg    <= step.state_next;
                nonempty_reg <= step.nonempty_next;
                line_reg     <= step.line_next;
                col_reg      <= step.col_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    xts_step u_step (
        .strict_quotes (strict_reg),
        .state         (state_reg),
        .nonempty      (nonempty_reg),
        .line_cnt      (line_reg),
        .col_cnt       (col_reg),
        .in_byte       (in_byte_reg),
        .step          (step)
    );

    xts_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (consume),
        .load_n    (step.n),
        .load_res0 (step.res0),
        .load_res1 (step.res1),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_res   (head),
        .can_load  (can_load)
    );

    assign m_tdata = {5'b0, head.col, head.line, head.code, head.vbyte};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

    // an error stands alone for its byte
    `XTS_ASSERT_NOW(a_err_last, m_tvalid && (m_tuser == KIND_ERROR), m_tlast, "error not last")
    // events carry no byte
    `XTS_ASSERT_NOW(a_evt_zero, m_tvalid && (m_tuser == KIND_EVENT), m_tdata[7:0] == 8'h00, "event byte set")
    // a counted newline restarts the column
    `XTS_ASSERT_NEXT(a_lf_col, consume && !step.err && (in_byte_reg == CH_LF), col_reg == 32'd0, "column not cleared")
    // a rejected byte leaves the scanner state alone
    `XTS_ASSERT_NEXT(a_err_hold, consume && step.err, state_reg == S_VAL_QUOTE, "state moved on error")

endmodule

>>> src/xts_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xts_step
// next-state logic of the scanner: one byte in, up to two results out
// ----------------------------------------------------------------------------
module xts_step (
    input  logic                 strict_quotes,
    input  xts_pkg::scan_state_t state,
    input  logic                 nonempty,
    input  logic [31:0]          line_cnt,
    input  logic [31:0]          col_cnt,
    input  logic [7:0]           in_byte,
    output xts_pkg::step_t       step
);
    import xts_pkg::*;

    logic is_ws;
    logic name_path;
    logic attr_path;
    logic noq_path;
    res_t r0;
    res_t r1;
    logic [1:0] n;
    logic err;
    scan_state_t nxt;
    res_t last_res;

    assign is_ws = (in_byte == CH_SP) || (in_byte == CH_TAB) ||
                   (in_byte == CH_CR) || (in_byte == CH_LF);

    always_comb begin
        name_path = 1'b0;
        attr_path = 1'b0;
        noq_path  = 1'b0;
        r0        = '0;
        r1        = '0;
        n         = 2'd0;
        err       = 1'b0;
        nxt       = state;

        case (state)
            S_NAME_BEGIN: begin
                if (in_byte == CH_SLASH) begin
                    nxt = S_CLOSE_NAME;
                end else begin
                    name_path = 1'b1;
                end
            end
            S_NAME: begin
                name_path = 1'b1;
            end
            S_CLOSE_NAME: begin
                if (in_byte == CH_GT) begin
                    r0  = mk_event(TOK_CLOSE_NAME);
                    n   = 2'd1;
                    nxt = S_TEXT;
                end else begin
                    r0 = mk_value(in_byte, TOK_CLOSE_NAME);
                    n  = 2'd1;
                end
            end
            S_CLOSE: begin
                if (in_byte == CH_GT) begin
                    r0  = mk_event(TOK_SELF_CLOSE);
                    n   = 2'd1;
                    nxt = S_TEXT;
                end
            end
            S_ATTR_BEGIN: begin
                if (is_ws) begin
                    nxt = state;
                end else if (in_byte == CH_SLASH) begin
                    nxt = S_CLOSE;
                end else if (in_byte == CH_GT) begin
                    r0  = mk_event(TOK_ATTRS_END);
                    n   = 2'd1;
                    nxt = S_TEXT;
                end else begin
                    attr_path = 1'b1;
                end
            end
            S_ATTR: begin
                attr_path = !is_ws;
            end
            S_VAL_QUOTE: begin
                if (is_ws) begin
                    nxt = state;
                end else if (in_byte == CH_DQ) begin
                    nxt = S_VAL_DQ;
                end else if (in_byte == CH_SQ) begin
                    nxt = S_VAL_SQ;
                end else if (strict_quotes) begin
                    // byte dropped, state and counters kept
                    r0       = '0;
                    r0.kind  = KIND_ERROR;
                    r0.vbyte = in_byte;
                    n        = 2'd1;
                    err      = 1'b1;
                end else begin
                    noq_path = 1'b1;
                end
            end
            S_VAL_NOQ: begin
                noq_path = 1'b1;
            end
            S_VAL_DQ: begin
                if (in_byte == CH_DQ) begin
                    r0  = mk_event(TOK_ATTR_VALUE);
                    n   = 2'd1;
                    nxt = S_ATTR_BEGIN;
                end else begin
                    r0 = mk_value(in_byte, TOK_ATTR_VALUE);
                    n  = 2'd1;
                end
            end
            S_VAL_SQ: begin
                if (in_byte == CH_SQ) begin
                    r0  = mk_event(TOK_ATTR_VALUE);
                    n   = 2'd1;
                    nxt = S_ATTR_BEGIN;
                end else begin
                    r0 = mk_value(in_byte, TOK_ATTR_VALUE);
                    n  = 2'd1;
                end
            end
            default: begin
                // text, and the unused codes behave as text
                if (in_byte == CH_LT) begin
                    if (nonempty) begin
                        r0 = mk_event(TOK_TEXT);
                        n  = 2'd1;
                    end
                    nxt = S_NAME_BEGIN;
                end else begin
                    r0 = mk_value(in_byte, TOK_TEXT);
                    n  = 2'd1;
                end
            end
        endcase

        if (name_path) begin
            if (in_byte == CH_SP) begin
                r0  = mk_event(TOK_TAG_OPEN);
                n   = 2'd1;
                nxt = S_ATTR_BEGIN;
            end else if (in_byte == CH_GT) begin
                r0  = mk_event(TOK_TAG_OPEN);
                r1  = mk_event(TOK_ATTRS_END);
                n   = 2'd2;
                nxt = S_TEXT;
            end else begin
                r0  = mk_value(in_byte, TOK_TAG_OPEN);
                n   = 2'd1;
                nxt = S_NAME;
            end
        end

        if (attr_path) begin
            if (in_byte == CH_EQ) begin
                r0  = mk_event(TOK_ATTR_NAME);
                n   = 2'd1;
                nxt = S_VAL_QUOTE;
            end else begin
                r0  = mk_value(in_byte, TOK_ATTR_NAME);
                n   = 2'd1;
                nxt = S_ATTR;
            end
        end

        if (noq_path) begin
            if (is_ws) begin
                r0  = mk_event(TOK_ATTR_VALUE);
                n   = 2'd1;
                nxt = S_ATTR_BEGIN;
            end else if (in_byte == CH_GT) begin
                r0  = mk_event(TOK_ATTR_VALUE);
                r1  = mk_event(TOK_ATTRS_END);
                n   = 2'd2;
                nxt = S_TEXT;
            end else begin
                r0  = mk_value(in_byte, TOK_ATTR_VALUE);
                n   = 2'd1;
                nxt = S_VAL_NOQ;
            end
        end
    end

    assign last_res = (n == 2'd2) ? r1 : r0;

    always_comb begin
        step            = '0;
        step.n          = n;
        step.err        = err;
        step.state_next = nxt;

        if (err) begin
            step.line_next = line_cnt;
            step.col_next  = col_cnt;
        end else if (in_byte == CH_LF) begin
            step.line_next = (line_cnt == CNT_MAX) ? line_cnt : line_cnt + 32'd1;
            step.col_next  = '0;
        end else begin
            step.line_next = line_cnt;
            step.col_next  = (col_cnt == CNT_MAX) ? col_cnt : col_cnt + 32'd1;
        end

        if ((n == 2'd0) || err) begin
            step.nonempty_next = nonempty;
        end else begin
            step.nonempty_next = (last_res.kind == KIND_VALUE);
        end

        step.res0      = r0;
        step.res1      = r1;
        step.res0.line = step.line_next;
        step.res0.col  = step.col_next;
        step.res0.last = (n == 2'd1);
        step.res1.line = step.line_next;
        step.res1.col  = step.col_next;
        step.res1.last = 1'b1;
    end

endmodule

>>> src/xts_obuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xts_obuf
// two-entry result register, drains one result per cycle while out_ready is high
// ----------------------------------------------------------------------------
module xts_obuf (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          load,
    input  logic [1:0]    load_n,
    input  xts_pkg::res_t load_res0,
    input  xts_pkg::res_t load_res1,
    input  logic          out_ready,
    output logic          out_valid,
    output xts_pkg::res_t out_res,
    output logic          can_load
);
    import xts_pkg::*;

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    res_t       r0_reg;
    res_t       r0_next;
    res_t       r1_reg;
    res_t       r1_next;
    logic       pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign out_res   = r0_reg;
    assign pop       = out_valid && out_ready;
    // refill when empty or as the last held result leaves
    assign can_load  = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_ready);

    always_comb begin
        cnt_next = cnt_reg;
        r0_next  = r0_reg;
        r1_next  = r1_reg;
        if (load) begin
            cnt_next = load_n;
            r0_next  = load_res0;
            r1_next  = load_res1;
        end else if (pop) begin
            cnt_next = cnt_reg - 2'd1;
            r0_next  = r1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        r0_reg <= r0_next;
        r1_reg <= r1_next;
    end

endmodule

>>> verif/xml_token_scanner_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_token_scanner_tb
// self-checking bench for the xml token scanner: a directed table walks the
// byte extremes, each token kind, empty text, tab inside a tag name, ignored
// bytes and the strict quote error; random document fragments and noise
// follow under three stall patterns and both quote modes. every result is
// compared against an in-bench scanner model
// ----------------------------------------------------------------------------
module xml_token_scanner_tb;
    import xts_pkg::*;

    localparam int          LAT_CYCLES  = 8;
    localparam int          DRAIN_LIMIT = 20000;
    localparam int          PHASE_ITEMS = 125;
    localparam logic [2:0]  TOK_NONE    = 3'd0;   // code field of an error result

    typedef struct packed {
        bit         is_cfg;    // data[0] is the strict_quotes value
        logic [7:0] data;
        bit         pin;       // kind and code typed in below
        logic [1:0] kind;
        logic [2:0] code;
    } dir_row_t;

    localparam dir_row_t DIR_TAB [28] = '{
        '{1'b1, 8'h00, 1'b0, KIND_VALUE, TOK_TEXT},
        '{1'b0, 8'h00, 1'b1, KIND_VALUE, TOK_TEXT},
        '{1'b0, 8'hFF, 1'b1, KIND_VALUE, TOK_TEXT},
        '{1'b0, CH_LT, 1'b1, KIND_EVENT, TOK_TEXT},
        '{1'b0, 8'h61, 1'b0, KIND_VALUE, TOK_TEXT},
        '{1'b0, CH_SP, 1'b0, KIND_VALUE, TOK_TEXT},
        '{1'b0, 8'h6B, 1'b0, KIND_VALUE, TOK_TEXT},
        '{1'b0, CH_EQ, 1'b0, KIND_VALUE, TOK_TEXT},
        '{1'b0, 8'h76, 1'b0, KIND_VALUE, TOK_TEXT},
        '{1'b0, CH_GT, 1'b0, KIND_VALUE, TOK_TEXT},
        '{1'b0, CH_LT, 1'b0, KIND_VALUE, TOK_TEXT},
        '{1'b0, CH_SLASH, 1'b0, KIND_VALUE, TOK_TEXT},
        '{1'b0, 8'h61, 1'b0, KIND_VALUE, TOK_TEXT},
        '{1'b0, CH_GT, 1'b0, KIND_VALUE, TOK_TEXT},
        '{1'b0, CH_LF, 1'b0, KIND_VALUE, TOK_TEXT},
        '{1'b1, 8'h01, 1'b0, KIND_VALUE, TOK_TEXT},
        '{1'b0, CH_LT, 1'b1, KIND_EVENT, TOK_TEXT},
        '{1'b0, 8'h62, 1'b0, KIND_VALUE, TOK_TEXT},
        '{1'b0, CH_TAB, 1'b0, KIND_VALUE, TOK_TEXT},
        '{1'b0, CH_SP, 1'b0, KIND_VALUE, TOK_TEXT},
        '{1'b0, 8'h78, 1'b0, KIND_VALUE, TOK_TEXT},
        '{1'b0, CH_EQ, 1'b0, KIND_VALUE, TOK_TEXT},
        '{1'b0, 8'h7A, 1'b1, KIND_ERROR, TOK_NONE},
        '{1'b0, CH_SQ, 1'b0, KIND_VALUE, TOK_TEXT},
        '{1'b0, CH_SQ, 1'b0, KIND_VALUE, TOK_TEXT},
        '{1'b0, CH_SLASH, 1'b0, KIND_VALUE, TOK_TEXT},
        '{1'b0, 8'h71, 1'b0, KIND_VALUE, TOK_TEXT},
        '{1'b0, CH_GT, 1'b1, KIND_EVENT, TOK_SELF_CLOSE}
    };

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = 8'h00;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [79:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // scanner model state
    scan_state_t scan_st      = S_TEXT;
    bit          text_pending = 1'b0;
    logic [31:0] line_cnt     = '0;
    logic [31:0] col_cnt      = '0;
    bit          strict_q     = 1'b0;

    res_t        step_buf [2];
    int          step_n;
    res_t        tokens_due [$];
    logic [7:0]  frag [$];

    int          src_idle   = 12;
    int          rcv_idle   = 63;
    int          busy_items = 0;
    int          fails      = 0;
    res_t        want;
    res_t        got;

    xml_token_scanner dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic bit is_space(input logic [7:0] b);
        return b == CH_SP || b == CH_TAB || b == CH_CR || b == CH_LF;
    endfunction

    function automatic void note_token(input logic [1:0] kind, input logic [7:0] vb,
                                       input logic [2:0] code);
        res_t r;
        r       = '0;
        r.kind  = kind;
        r.vbyte = vb;
        r.code  = code;
        step_buf[step_n] = r;
        step_n++;
        if (kind == KIND_VALUE) begin
            text_pending = 1'b1;
        end else if (kind == KIND_EVENT) begin
            text_pending = 1'b0;
        end
    endfunction

    // next state and results of one document byte
    function automatic void scan_byte(input logic [7:0] b);
        scan_state_t st;
        bit          noq;
        st     = scan_st;
        noq    = 1'b0;
        step_n = 0;
        case (st)
            S_NAME_BEGIN, S_NAME: begin
                if (st == S_NAME_BEGIN && b == CH_SLASH) begin
                    st = S_CLOSE_NAME;
                end else if (b == CH_SP) begin
                    note_token(KIND_EVENT, 8'h00, TOK_TAG_OPEN);
                    st = S_ATTR_BEGIN;
                end else if (b == CH_GT) begin
                    note_token(KIND_EVENT, 8'h00, TOK_TAG_OPEN);
                    note_token(KIND_EVENT, 8'h00, TOK_ATTRS_END);
                    st = S_TEXT;
                end else begin
                    note_token(KIND_VALUE, b, TOK_TAG_OPEN);
                    st = S_NAME;
                end
            end
            S_CLOSE_NAME: begin
                if (b == CH_GT) begin
                    note_token(KIND_EVENT, 8'h00, TOK_CLOSE_NAME);
                    st = S_TEXT;
                end else begin
                    note_token(KIND_VALUE, b, TOK_CLOSE_NAME);
                end
            end
            S_CLOSE: begin
                if (b == CH_GT) begin
                    note_token(KIND_EVENT, 8'h00, TOK_SELF_CLOSE);
                    st = S_TEXT;
                end
            end
            S_ATTR_BEGIN, S_ATTR: begin
                if (is_space(b)) begin
                    // skipped between attributes
                end else if (st == S_ATTR_BEGIN && b == CH_SLASH) begin
                    st = S_CLOSE;
                end else if (st == S_ATTR_BEGIN && b == CH_GT) begin
                    note_token(KIND_EVENT, 8'h00, TOK_ATTRS_END);
                    st = S_TEXT;
                end else if (b == CH_EQ) begin
                    note_token(KIND_EVENT, 8'h00, TOK_ATTR_NAME);
                    st = S_VAL_QUOTE;
                end else begin
                    note_token(KIND_VALUE, b, TOK_ATTR_NAME);
                    st = S_ATTR;
                end
            end
            S_VAL_QUOTE: begin
                if (is_space(b)) begin
                    // waiting for the value
                end else if (b == CH_DQ) begin
                    st = S_VAL_DQ;
                end else if (b == CH_SQ) begin
                    st = S_VAL_SQ;
                end else if (strict_q) begin
                    // byte dropped: no state change, counters untouched
                    note_token(KIND_ERROR, b, TOK_NONE);
                    step_buf[0].line = line_cnt;
                    step_buf[0].col  = col_cnt;
                    step_buf[0].last = 1'b1;
                    return;
                end else begin
                    noq = 1'b1;
                end
            end
            S_VAL_NOQ: noq = 1'b1;
            S_VAL_DQ: begin
                if (b == CH_DQ) begin
                    note_token(KIND_EVENT, 8'h00, TOK_ATTR_VALUE);
                    st = S_ATTR_BEGIN;
                end else begin
                    note_token(KIND_VALUE, b, TOK_ATTR_VALUE);
                end
            end
            S_VAL_SQ: begin
                if (b == CH_SQ) begin
                    note_token(KIND_EVENT, 8'h00, TOK_ATTR_VALUE);
                    st = S_ATTR_BEGIN;
                end else begin
                    note_token(KIND_VALUE, b, TOK_ATTR_VALUE);
                end
            end
            default: begin
                if (b == CH_LT) begin
                    if (text_pending) begin
                        note_token(KIND_EVENT, 8'h00, TOK_TEXT);
                    end
                    st = S_NAME_BEGIN;
                end else begin
                    note_token(KIND_VALUE, b, TOK_TEXT);
                end
            end
        endcase
        if (noq) begin
            if (is_space(b)) begin
                note_token(KIND_EVENT, 8'h00, TOK_ATTR_VALUE);
                st = S_ATTR_BEGIN;
            end else if (b == CH_GT) begin
                note_token(KIND_EVENT, 8'h00, TOK_ATTR_VALUE);
                note_token(KIND_EVENT, 8'h00, TOK_ATTRS_END);
                st = S_TEXT;
            end else begin
                note_token(KIND_VALUE, b, TOK_ATTR_VALUE);
                st = S_VAL_NOQ;
            end
        end
        scan_st = st;
        if (b == CH_LF) begin
            if (line_cnt != CNT_MAX) begin
                line_cnt = line_cnt + 1;
            end
            col_cnt = '0;
        end else if (col_cnt != CNT_MAX) begin
            col_cnt = col_cnt + 1;
        end
        for (int k = 0; k < step_n; k++) begin
            step_buf[k].line = line_cnt;
            step_buf[k].col  = col_cnt;
            step_buf[k].last = (k == step_n - 1);
        end
    endfunction

    function automatic logic [7:0] rand_letter();
        return 8'h61 + 8'($urandom_range(25));
    endfunction

    function automatic logic [7:0] rand_ws();
        case ($urandom_range(3))
            0:       return CH_SP;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    // one piece of a document: mostly well-formed tags and text, some noise
    function automatic void gen_fragment();
        int         sel;
        int         n;
        int         qs;
        logic [7:0] q;
        logic [7:0] c;
        frag.delete();
        sel = $urandom_range(99);
        if (sel < 12) begin
            n = $urandom_range(1, 6);
            repeat (n) frag.push_back(8'($urandom_range(255)));
        end else if (sel < 35) begin
            n = $urandom_range(1, 8);
            repeat (n) begin
                case ($urandom_range(9))
                    0:       c = CH_LF;
                    1:       c = CH_SP;
                    2:       c = 8'($urandom_range(128, 255));
                    3:       c = 8'($urandom_range(33, 126));
                    default: c = rand_letter();
                endcase
                frag.push_back(c == CH_LT ? rand_letter() : c);
            end
        end else if (sel < 80) begin
            frag.push_back(CH_LT);
            n = $urandom_range(1, 5);
            repeat (n) frag.push_back($urandom_range(9) == 0 ? CH_TAB : rand_letter());
            repeat ($urandom_range(0, 3)) begin
                frag.push_back(CH_SP);
                if ($urandom_range(3) == 0) frag.push_back(rand_ws());
                n = $urandom_range(1, 4);
                repeat (n) frag.push_back(rand_letter());
                if ($urandom_range(3) == 0) frag.push_back(rand_ws());
                frag.push_back(CH_EQ);
                if ($urandom_range(3) == 0) frag.push_back(rand_ws());
                qs = $urandom_range(99);
                if (qs < (strict_q ? 5 : 30)) begin
                    n = $urandom_range(1, 4);
                    repeat (n) frag.push_back(rand_letter());
                    frag.push_back(rand_ws());
                end else begin
                    q = qs[0] ? CH_DQ : CH_SQ;
                    frag.push_back(q);
                    repeat ($urandom_range(0, 5)) begin
                        case ($urandom_range(5))
                            0:       frag.push_back(q == CH_DQ ? CH_SQ : CH_DQ);
                            1:       frag.push_back(CH_SP);
                            2:       frag.push_back(CH_GT);
                            default: frag.push_back(rand_letter());
                        endcase
                    end
                    frag.push_back(q);
                end
            end
            if ($urandom_range(2) == 0) frag.push_back(CH_SP);
            if ($urandom_range(3) == 0) begin
                frag.push_back(CH_SLASH);
                if ($urandom_range(3) == 0) frag.push_back(rand_letter());
            end
            frag.push_back(CH_GT);
        end else if (sel < 95) begin
            frag.push_back(CH_LT);
            frag.push_back(CH_SLASH);
            n = $urandom_range(1, 4);
            repeat (n) frag.push_back(rand_letter());
            frag.push_back(CH_GT);
        end else begin
            frag.push_back(CH_LT);
            n = $urandom_range(1, 4);
            repeat (n) begin
                case ($urandom_range(6))
                    0:       frag.push_back(CH_SLASH);
                    1:       frag.push_back(CH_EQ);
                    2:       frag.push_back(CH_DQ);
                    3:       frag.push_back(CH_SQ);
                    4:       frag.push_back(CH_GT);
                    5:       frag.push_back(CH_SP);
                    default: frag.push_back(rand_letter());
                endcase
            end
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit pin, input logic [1:0] pk,
                             input logic [2:0] pc);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        scan_byte(b);
        if (pin) begin
            step_buf[0].kind  = pk;
            step_buf[0].vbyte = (pk == KIND_EVENT) ? 8'h00 : b;
            step_buf[0].code  = pc;
        end
        for (int k = 0; k < step_n; k++) tokens_due.push_back(step_buf[k]);
        if (step_n != 0) busy_items++;
        @(negedge aclk);
    endtask

    // stop requests and let the scanner go quiet
    task automatic settle();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (tokens_due.size() != 0 && guard < DRAIN_LIMIT) begin
            @(negedge aclk);
            guard++;
        end
        repeat (LAT_CYCLES) @(negedge aclk);
    endtask

    task automatic write_strict(input bit v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        strict_q     = v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= rcv_idle);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got.kind  = m_tuser;
            got.vbyte = m_tdata[7:0];
            got.code  = m_tdata[10:8];
            got.line  = m_tdata[42:11];
            got.col   = m_tdata[74:43];
            got.last  = m_tlast;
            if (tokens_due.size() == 0) begin
                fails++;
                if (fails <= 10) begin
                    $display("%0t unexpected result kind %0d byte %h code %0d", $realtime,
                             got.kind, got.vbyte, got.code);
                end
            end else begin
                want = tokens_due.pop_front();
                if (got !== want) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("%0t mismatch exp/got kind %0d/%0d byte %h/%h code %0d/%0d",
                                 $realtime, want.kind, got.kind, want.vbyte, got.vbyte,
                                 want.code, got.code);
                        $display("    line %0d/%0d col %0d/%0d last %0d/%0d",
                                 want.line, got.line, want.col, got.col, want.last, got.last);
                    end
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int pause_at;
        bit paused;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (DIR_TAB[i]) begin
            if (DIR_TAB[i].is_cfg) begin
                settle();
                write_strict(DIR_TAB[i].data[0]);
            end else begin
                send_byte(DIR_TAB[i].data, DIR_TAB[i].pin, DIR_TAB[i].kind, DIR_TAB[i].code);
            end
        end

        for (int ph = 0; ph < 3; ph++) begin
            src_idle = (ph == 0) ? 12 : (ph == 1) ? 63 : 0;
            rcv_idle = (ph == 0) ? 63 : (ph == 1) ? 12 : 0;
            settle();
            write_strict(ph == 1);
            busy_items = 0;
            paused     = 1'b0;
            pause_at   = $urandom_range(20, 100);
            while (busy_items < PHASE_ITEMS) begin
                // hold off once per phase until the result side is empty
                if (!paused && busy_items >= pause_at) begin
                    settle();
                    paused = 1'b1;
                end
                gen_fragment();
                foreach (frag[i]) send_byte(frag[i], 1'b0, KIND_VALUE, TOK_TEXT);
            end
        end

        settle();
        fails += tokens_due.size();
        if (fails == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
